// ===== rtl/set_assoc_cache_directory_plru_defines.svh =====
// assertion macros for the cache directory checker
// no dependencies; expects clk and rst_n in the scope where a macro is used
`ifndef SET_ASSOC_CACHE_DIRECTORY_PLRU_DEFINES_SVH
`define SET_ASSOC_CACHE_DIRECTORY_PLRU_DEFINES_SVH

// same-cycle implication
`define SACD_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacd assertion failed");

// next-cycle implication
`define SACD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacd assertion failed");

`endif

// ===== rtl/sacd_pkg.sv =====
// shared types, widths and plru tables for the cache directory
// no dependencies
package sacd_pkg;

    localparam int ADDR_W          = 32;
    localparam int CNT_W           = 32;
    localparam int NUM_WAYS        = 4;
    localparam int WAY_W           = 2;
    localparam int PLRU_W          = 3;
    localparam int DEF_NUM_SETS    = 32;
    localparam int DEF_LINE_BYTES  = 32;

    // victim way for each plru state
    localparam logic [WAY_W-1:0] VICTIM_OF_STATE [8] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
    };

    // next plru state, indexed by {state, referenced way}
    localparam logic [PLRU_W-1:0] PLRU_NEXT [32] = '{
        3'd6, 3'd4, 3'd1, 3'd0,
        3'd7, 3'd5, 3'd1, 3'd0,
        3'd6, 3'd4, 3'd3, 3'd2,
        3'd7, 3'd5, 3'd3, 3'd2,
        3'd6, 3'd4, 3'd1, 3'd0,
        3'd7, 3'd5, 3'd1, 3'd0,
        3'd6, 3'd4, 3'd3, 3'd2,
        3'd7, 3'd5, 3'd3, 3'd2
    };

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic clr_step;
        logic commit;
    } sacd_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } sacd_status_t;

endpackage

// ===== rtl/sacd_if.sv =====
// request and response channel interfaces of the cache directory
// depends on sacd_pkg
interface sacd_req_if
    import sacd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic              is_write;

    modport source (output valid, output address, output is_write, input ready);
    modport sink   (input valid, input address, input is_write, output ready);
endinterface

interface sacd_rsp_if
    import sacd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             write_back;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] writeback_count;

    modport source (
        output valid, output hit, output way, output write_back,
        output read_count, output write_count, output hit_count,
        output miss_count, output writeback_count,
        input ready
    );
    modport sink (
        input valid, input hit, input way, input write_back,
        input read_count, input write_count, input hit_count,
        input miss_count, input writeback_count,
        output ready
    );
endinterface

// ===== rtl/sacd_ctrl.sv =====
// controller state machine: clearing pass, request capture, directory read, update
// depends on sacd_pkg
module sacd_ctrl
    import sacd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sacd_status_t status,
    output sacd_cmd_t    cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ===== rtl/sacd_datapath.sv =====
// directory memory, lookup and replacement logic, counters and response register
// depends on sacd_pkg
module sacd_datapath
    import sacd_pkg::*;
#(
    parameter int NUM_SETS   = DEF_NUM_SETS,
    parameter int LINE_BYTES = DEF_LINE_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sacd_cmd_t         cmd,
    output sacd_status_t      status,
    input  logic [ADDR_W-1:0] address,
    input  logic              is_write,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              hit,
    output logic [WAY_W-1:0]  way,
    output logic              write_back,
    output logic [CNT_W-1:0]  read_count,
    output logic [CNT_W-1:0]  write_count,
    output logic [CNT_W-1:0]  hit_count,
    output logic [CNT_W-1:0]  miss_count,
    output logic [CNT_W-1:0]  writeback_count
);

    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int IDX_W     = $clog2(NUM_SETS);
    localparam int TAG_W     = ADDR_W - OFF_W - IDX_W;
    localparam int DIRTY_LSB = NUM_WAYS * TAG_W;
    localparam int VALID_LSB = DIRTY_LSB + NUM_WAYS;
    localparam int PLRU_LSB  = VALID_LSB + NUM_WAYS;
    localparam int ROW_W     = PLRU_LSB + PLRU_W;

    // row layout: {plru, valid, dirty, tag3, tag2, tag1, tag0}
    logic [ROW_W-1:0] dir_mem [NUM_SETS];

    logic [IDX_W-1:0]    idx_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic                wr_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [IDX_W-1:0]    clr_idx_reg;
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [WAY_W-1:0]    out_way_reg;
    logic                out_wb_reg;
    logic [CNT_W-1:0]    read_cnt_reg;
    logic [CNT_W-1:0]    write_cnt_reg;
    logic [CNT_W-1:0]    hit_cnt_reg;
    logic [CNT_W-1:0]    miss_cnt_reg;
    logic [CNT_W-1:0]    wb_cnt_reg;

    logic [NUM_WAYS-1:0] row_valid;
    logic [NUM_WAYS-1:0] row_dirty;
    logic [PLRU_W-1:0]   row_plru;
    logic [NUM_WAYS-1:0] match;
    logic                lk_hit;
    logic [WAY_W-1:0]    lk_way;
    logic                lk_wb;
    logic [NUM_WAYS-1:0] way_onehot;
    logic [NUM_WAYS-1:0] new_valid;
    logic [NUM_WAYS-1:0] new_dirty;
    logic [DIRTY_LSB-1:0] new_tags;
    logic [ROW_W-1:0]    new_row;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;

    function automatic logic [WAY_W-1:0] first_one(input logic [NUM_WAYS-1:0] v);
        logic [WAY_W-1:0] r;
        r = 2'd3;
        if (v[0])
        begin
            r = 2'd0;
        end
        else if (v[1])
        begin
            r = 2'd1;
        end
        else if (v[2])
        begin
            r = 2'd2;
        end
        return r;
    endfunction

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= address[OFF_W +: IDX_W];
            tag_reg <= address[ADDR_W-1 -: TAG_W];
            wr_reg  <= is_write;
        end
    end

    // directory memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dir_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            row_reg <= dir_mem[idx_reg];
        end
    end

    assign mem_we    = cmd.clr_step | cmd.commit;
    assign mem_waddr = cmd.clr_step ? clr_idx_reg : idx_reg;
    assign mem_wdata = cmd.clr_step ? '0 : new_row;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_idx_reg <= clr_idx_reg + IDX_W'(1);
        end
    end

    assign status.clr_last = (clr_idx_reg == IDX_W'(NUM_SETS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    // lookup and replacement
    assign row_valid  = row_reg[VALID_LSB +: NUM_WAYS];
    assign row_dirty  = row_reg[DIRTY_LSB +: NUM_WAYS];
    assign row_plru   = row_reg[PLRU_LSB +: PLRU_W];

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            match[w] = row_valid[w] && (row_reg[w*TAG_W +: TAG_W] == tag_reg);
        end
    end

    assign lk_hit = |match;

    always_comb
    begin
        if (lk_hit)
        begin
            lk_way = first_one(match);
        end
        else if (!(&row_valid))
        begin
            lk_way = first_one(~row_valid);
        end
        else
        begin
            lk_way = VICTIM_OF_STATE[row_plru];
        end
    end

    assign way_onehot = {{(NUM_WAYS-1){1'b0}}, 1'b1} << lk_way;
    assign lk_wb      = !lk_hit && |(way_onehot & row_valid & row_dirty);
    assign new_valid  = row_valid | way_onehot;

    always_comb
    begin
        new_dirty = lk_hit ? row_dirty : (row_dirty & ~way_onehot);
        if (wr_reg)
        begin
            new_dirty = new_dirty | way_onehot;
        end
    end

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            new_tags[w*TAG_W +: TAG_W] = way_onehot[w] ? tag_reg : row_reg[w*TAG_W +: TAG_W];
        end
    end

    assign new_row = {PLRU_NEXT[{row_plru, lk_way}], new_valid, new_dirty, new_tags};

    // counters and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            read_cnt_reg  <= '0;
            write_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            wb_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (wr_reg)
                begin
                    write_cnt_reg <= write_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    read_cnt_reg <= read_cnt_reg + CNT_W'(1);
                end
                if (lk_hit)
                begin
                    hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                end
                if (lk_wb)
                begin
                    wb_cnt_reg <= wb_cnt_reg + CNT_W'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg <= lk_hit;
            out_way_reg <= lk_way;
            out_wb_reg  <= lk_wb;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = out_hit_reg;
    assign way             = out_way_reg;
    assign write_back      = out_wb_reg;
    assign read_count      = read_cnt_reg;
    assign write_count     = write_cnt_reg;
    assign hit_count       = hit_cnt_reg;
    assign miss_count      = miss_cnt_reg;
    assign writeback_count = wb_cnt_reg;

endmodule

// ===== rtl/set_assoc_cache_directory_plru.sv =====
// Tag directory of a 4-way set-associative write-back cache with tree pseudo-LRU
// replacement and five wrapping 32-bit access counters; no line data is kept.
// Each request passes through capture, directory read and update, and the next
// request is accepted on the cycle after the update, so requests are taken one at
// a time; the directory memory is read then written once per request. The response
// sits in an output register, so a new request is taken while the previous response
// waits; the update stalls only when a second response is ready before the first
// was taken. After reset a clearing pass zeroes every set of the directory, with
// req.ready held low. NUM_SETS and LINE_BYTES are to be powers of two; the block
// itself does not enforce this. Depends on sacd_pkg, sacd_if, sacd_ctrl and
// sacd_datapath.
module set_assoc_cache_directory_plru
    import sacd_pkg::*;
#(
    parameter int NUM_SETS   = DEF_NUM_SETS,
    parameter int LINE_BYTES = DEF_LINE_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    sacd_req_if.sink   req,
    sacd_rsp_if.source rsp
);

    sacd_cmd_t    cmd;
    sacd_status_t status;

    sacd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sacd_datapath #(
        .NUM_SETS   (NUM_SETS),
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .address         (req.address),
        .is_write        (req.is_write),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .hit             (rsp.hit),
        .way             (rsp.way),
        .write_back      (rsp.write_back),
        .read_count      (rsp.read_count),
        .write_count     (rsp.write_count),
        .hit_count       (rsp.hit_count),
        .miss_count      (rsp.miss_count),
        .writeback_count (rsp.writeback_count)
    );

endmodule

// ===== rtl/sacd_checker.sv =====
// port-level assertions for the cache directory, bound to the top level
// depends on sacd_pkg and set_assoc_cache_directory_plru_defines.svh
`include "set_assoc_cache_directory_plru_defines.svh"

module sacd_checker
    import sacd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             hit,
    input logic [WAY_W-1:0] way,
    input logic             write_back,
    input logic [CNT_W-1:0] read_count,
    input logic [CNT_W-1:0] write_count,
    input logic [CNT_W-1:0] hit_count,
    input logic [CNT_W-1:0] miss_count,
    input logic [CNT_W-1:0] writeback_count
);

    localparam int PAYLOAD_W = 2 + WAY_W + 5 * CNT_W;

    logic [PAYLOAD_W-1:0] rsp_payload;

    assign rsp_payload = {hit, way, write_back, read_count, write_count, hit_count,
                          miss_count, writeback_count};

    `SACD_ASSERT_NEXT(a_rsp_valid_holds, (rsp_valid && !rsp_ready), rsp_valid)
    `SACD_ASSERT_NEXT(a_rsp_payload_holds, (rsp_valid && !rsp_ready), ($stable(rsp_payload)))
    `SACD_ASSERT_NEXT(a_one_request_at_a_time, (req_valid && req_ready), !req_ready)
    `SACD_ASSERT_NOW(a_hit_never_writes_back, rsp_valid, !(hit && write_back))
    `SACD_ASSERT_NOW(a_counts_balance, rsp_valid, ((read_count + write_count) == (hit_count + miss_count)))

endmodule

bind set_assoc_cache_directory_plru sacd_checker u_sacd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .hit             (rsp.hit),
    .way             (rsp.way),
    .write_back      (rsp.write_back),
    .read_count      (rsp.read_count),
    .write_count     (rsp.write_count),
    .hit_count       (rsp.hit_count),
    .miss_count      (rsp.miss_count),
    .writeback_count (rsp.writeback_count)
);

// ===== tb/sacd_directory_checker.sv =====
// checker for the cache directory: watches the request and response channels,
// predicts each response from a model of the tags, plru and counters, and compares
// depends on sacd_pkg and the sacd_req_if / sacd_rsp_if interfaces
module sacd_directory_checker
    import sacd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sacd_req_if  req,
    sacd_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS     = DEF_NUM_SETS;
    localparam int OFFSET_W = $clog2(DEF_LINE_BYTES);
    localparam int SET_W    = $clog2(DEF_NUM_SETS);
    localparam int TAG_W    = ADDR_W - SET_W - OFFSET_W;

    typedef struct {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             write_back;
        logic [CNT_W-1:0] reads;
        logic [CNT_W-1:0] writes;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] writebacks;
    } access_result_t;

    logic [PLRU_W-1:0]   plru_tree [SETS];
    logic [NUM_WAYS-1:0] valid_mask [SETS];
    logic [NUM_WAYS-1:0] dirty_mask [SETS];
    logic [TAG_W-1:0]    tag_of [NUM_WAYS][SETS];
    logic [CNT_W-1:0]    reads_total;
    logic [CNT_W-1:0]    writes_total;
    logic [CNT_W-1:0]    hits_total;
    logic [CNT_W-1:0]    misses_total;
    logic [CNT_W-1:0]    writebacks_total;

    access_result_t expected_q [$];
    access_result_t want;
    int             fail_total;
    int             s;

    function automatic logic [WAY_W-1:0] plru_victim(logic [PLRU_W-1:0] st);
        return st[2] ? {1'b1, st[0]} : {1'b0, st[1]};
    endfunction

    function automatic logic [PLRU_W-1:0] plru_touch(logic [PLRU_W-1:0] st,
                                                     logic [WAY_W-1:0] w);
        case (w)
            2'd0:    return {2'b11, st[0]};
            2'd1:    return {2'b10, st[0]};
            2'd2:    return {1'b0, st[1], 1'b1};
            default: return {1'b0, st[1], 1'b0};
        endcase
    endfunction

    function automatic access_result_t predict_access(logic [ADDR_W-1:0] addr, logic wr);
        access_result_t   r;
        logic [SET_W-1:0] set;
        logic [TAG_W-1:0] tag;
        logic             found;
        int               w;
        set          = addr[OFFSET_W +: SET_W];
        tag          = addr[ADDR_W-1 -: TAG_W];
        found        = 1'b0;
        r.hit        = 1'b0;
        r.way        = '0;
        r.write_back = 1'b0;
        if (wr)
            writes_total++;
        else
            reads_total++;
        for (w = 0; w < NUM_WAYS; w++)
        begin
            if (!found && valid_mask[set][w] && tag_of[w][set] == tag)
            begin
                found = 1'b1;
                r.way = WAY_W'(w);
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            hits_total++;
        end
        else
        begin
            misses_total++;
            if (valid_mask[set] != '1)
            begin
                for (w = NUM_WAYS - 1; w >= 0; w--)
                begin
                    if (!valid_mask[set][w])
                        r.way = WAY_W'(w);
                end
            end
            else
                r.way = plru_victim(plru_tree[set]);
            if (valid_mask[set][r.way] && dirty_mask[set][r.way])
            begin
                r.write_back = 1'b1;
                writebacks_total++;
            end
            valid_mask[set][r.way] = 1'b1;
            dirty_mask[set][r.way] = 1'b0;
            tag_of[r.way][set]     = tag;
        end
        plru_tree[set] = plru_touch(plru_tree[set], r.way);
        if (wr)
            dirty_mask[set][r.way] = 1'b1;
        r.reads      = reads_total;
        r.writes     = writes_total;
        r.hits       = hits_total;
        r.misses     = misses_total;
        r.writebacks = writebacks_total;
        return r;
    endfunction

    task automatic check_field(string name, logic [CNT_W-1:0] exp_val,
                               logic [CNT_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (s = 0; s < SETS; s++)
            begin
                plru_tree[s]  = '0;
                valid_mask[s] = '0;
                dirty_mask[s] = '0;
                for (int w = 0; w < NUM_WAYS; w++)
                    tag_of[w][s] = '0;
            end
            reads_total      = '0;
            writes_total     = '0;
            hits_total       = '0;
            misses_total     = '0;
            writebacks_total = '0;
            expected_q.delete();
            fail_total  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_q.push_back(predict_access(req.address, req.is_write));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: response expected none got hit %0b way %0d",
                             $time, rsp.hit, rsp.way);
                    fail_total++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("hit", CNT_W'(want.hit), CNT_W'(rsp.hit));
                    check_field("way", CNT_W'(want.way), CNT_W'(rsp.way));
                    check_field("write_back", CNT_W'(want.write_back), CNT_W'(rsp.write_back));
                    check_field("read_count", want.reads, rsp.read_count);
                    check_field("write_count", want.writes, rsp.write_count);
                    check_field("hit_count", want.hits, rsp.hit_count);
                    check_field("miss_count", want.misses, rsp.miss_count);
                    check_field("writeback_count", want.writebacks, rsp.writeback_count);
                end
            end
            mismatches  <= fail_total;
            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== tb/set_assoc_cache_directory_plru_tb.sv =====
// top of the cache directory testbench: clock, reset, request stimulus and
// response back-pressure; checking is done by sacd_directory_checker
// depends on sacd_pkg, the sacd interfaces, the directory and the checker
module set_assoc_cache_directory_plru_tb;
    import sacd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ACCESSES = 650;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int TAG_W           = ADDR_W - $clog2(DEF_NUM_SETS) - $clog2(DEF_LINE_BYTES);

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;
    int   hold_ticket;
    int   cycles = 0;
    int   mismatches;
    int   outstanding;

    logic [TAG_W-1:0] tag_pool [8];

    sacd_req_if req_ch ();
    sacd_rsp_if rsp_ch ();

    set_assoc_cache_directory_plru dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sacd_directory_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // response back-pressure, with one long hold-off per ticket
    initial
    begin
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != served)
            begin
                served    = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (quiet)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic send_access(logic [ADDR_W-1:0] addr, logic wr);
        req_ch.valid    <= 1'b1;
        req_ch.address  <= addr;
        req_ch.is_write <= wr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 99) < 33)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.address  <= $urandom;
            req_ch.is_write <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int               n;
        int               pick;
        logic [4:0]       set;
        logic [ADDR_W-1:0] addr;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.address  <= '0;
        req_ch.is_write <= 1'b0;
        quiet           <= 1'b0;
        hold_ticket     <= 0;
        for (n = 0; n < 8; n++)
            tag_pool[n] = TAG_W'($urandom);
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // sets 0 and 31: cold miss, write hit, fill all ways, then dirty evictions
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_001F, 1'b1);
        for (n = 1; n <= 5; n++)
            send_access({TAG_W'(n), 5'd0, 5'd0}, n[0]);
        send_access(32'h0000_0400, 1'b1);
        for (n = 6; n <= 9; n++)
            send_access({TAG_W'(n), 5'd0, 5'($urandom)}, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'hFFFF_FFE0, 1'b0);
        send_access(32'h8000_03E0, 1'b0);
        send_access(32'h0000_03FF, 1'b1);
        send_access(32'h7FFF_FC1F, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b0);
        wait_drained();

        for (n = 0; n < RANDOM_ACCESSES; n++)
        begin
            if (n == 150)
                quiet <= 1'b1;
            if (n == 300)
                quiet <= 1'b0;
            if (n == 450)
                hold_ticket <= hold_ticket + 1;
            pick = $urandom_range(0, 99);
            if (pick < 15)
                addr = $urandom;
            else
            begin
                set  = (pick < 70) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
                addr = {tag_pool[$urandom_range(0, 7)], set, 5'($urandom)};
            end
            send_access(addr, 1'($urandom_range(0, 1)));
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sacd_pkg.sv
rtl/sacd_if.sv
rtl/sacd_ctrl.sv
rtl/sacd_datapath.sv
rtl/set_assoc_cache_directory_plru.sv
rtl/sacd_checker.sv
tb/sacd_directory_checker.sv
tb/set_assoc_cache_directory_plru_tb.sv
